>>> hdl/hwo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwo_pkg
// shared types and constants of the additive harmonic oscillator
// ----------------------------------------------------------------------------
package hwo_pkg;

    // base waveform codes
    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_SQUARE = 2'd2,
        WAVE_TRI    = 2'd3
    } t_wave;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_WAVE  = 2'd0;
    localparam logic [1:0] CFG_IDX_COUNT = 2'd1;
    localparam logic [1:0] CFG_IDX_DECAY = 2'd2;

    localparam logic [1:0]  RST_WAVE  = 2'd0;
    localparam logic [3:0]  RST_COUNT = 4'd5;
    localparam logic [15:0] RST_DECAY = 16'd32768;

    // widths of the coefficient and datapath words
    localparam int unsigned POW_W     = 33;   // Q0.32 powers, up to one
    localparam int unsigned WEIGHT_W  = 25;   // Q0.24 weights, up to one
    localparam int unsigned BASE_W    = 34;   // low bits of time*freq that reach the phase
    localparam int unsigned CONTRIB_W = 36;   // signed per-harmonic term, Q.30

    localparam logic [32:0] ONE_Q32          = 33'h1_0000_0000;
    localparam logic [31:0] HALF_PI_Q30      = 32'd1686629713;
    localparam logic [31:0] SQUARE_SCALE_Q30 = 32'd1063004406;
    localparam logic [31:0] HALF_Q30         = 32'h2000_0000;

    localparam int OUT_MAX = 524287;
    localparam int OUT_MIN = -524288;

endpackage

>>> hdl/hwo_coef.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwo_coef
// decay powers and harmonic weights, rebuilt after reset and register writes
// ----------------------------------------------------------------------------
module hwo_coef #(
    parameter int MAX_HARMONICS = 8,
    parameter int CNT_W         = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [15:0]                   i_decay,
    input  logic [CNT_W-1:0]              i_count,
    output logic [hwo_pkg::POW_W-1:0]     o_pow    [MAX_HARMONICS],
    output logic [hwo_pkg::WEIGHT_W-1:0]  o_weight [MAX_HARMONICS],
    output logic                          o_busy
);

    localparam int IDX_W     = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int NUM_W     = 57;
    localparam int DIV_LAST  = NUM_W - 1;
    localparam int BIT_W     = $clog2(NUM_W);
    localparam int WW        = hwo_pkg::WEIGHT_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_POW  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_DIV  = 4'b1000
    } t_coef_state;

    t_coef_state r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx;
    logic [BIT_W-1:0] r_bit;
    logic [32:0]      r_cur;
    logic [32:0]      r_pn;
    logic [32:0]      r_den;
    logic [32:0]      r_rem;
    logic [NUM_W-1:0] r_num;
    logic [WW-1:0]    r_q;
    logic [32:0]      r_pow [MAX_HARMONICS];
    logic [WW-1:0]    r_w   [MAX_HARMONICS];

    logic [48:0] w_cur_prod;
    logic [49:0] w_num_prod;
    logic [33:0] w_trial;
    logic        w_qbit;
    logic [33:0] w_diff;

    assign w_cur_prod = r_cur * i_decay;
    assign w_num_prod = r_pow[r_idx] * (17'h1_0000 - {1'b0, i_decay});
    assign w_trial    = {r_rem, r_num[NUM_W-1]};
    assign w_qbit     = (w_trial >= {1'b0, r_den});
    assign w_diff     = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_POW;
            r_cnt   <= '0;
            r_cur   <= hwo_pkg::ONE_Q32;
        end else if (i_start) begin
            r_state <= ST_POW;
            r_cnt   <= '0;
            r_cur   <= hwo_pkg::ONE_Q32;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_state <= ST_IDLE;
                end
                ST_POW: begin
                    if (int'(r_cnt) < MAX_HARMONICS) begin
                        r_pow[r_cnt[IDX_W-1:0]] <= r_cur;
                    end
                    if (r_cnt == i_count) begin
                        r_pn <= r_cur;
                    end
                    r_cur <= w_cur_prod[48:16];
                    r_cnt <= r_cnt + 1'b1;
                    if (int'(r_cnt) == MAX_HARMONICS) begin
                        r_state <= ST_MUL;
                        r_idx   <= '0;
                    end
                end
                ST_MUL: begin
                    r_num   <= {w_num_prod[48:0], 8'd0};
                    r_den   <= hwo_pkg::ONE_Q32 - r_pn;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_bit   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit a cycle
                    r_rem <= w_qbit ? w_diff[32:0] : w_trial[32:0];
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_q   <= {r_q[WW-2:0], w_qbit};
                    r_bit <= r_bit + 1'b1;
                    if (int'(r_bit) == DIV_LAST) begin
                        r_w[r_idx] <= {r_q[WW-2:0], w_qbit};
                        if (int'(r_idx) == MAX_HARMONICS - 1) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_pow    = r_pow;
    assign o_weight = r_w;
    assign o_busy   = (r_state != ST_IDLE);

endmodule

>>> hdl/hwo_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwo_lane
// one harmonic: phase, amplitude, waveform and weighted term in seven stages
// ----------------------------------------------------------------------------
module hwo_lane #(
    parameter int HARM            = 1,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [hwo_pkg::BASE_W-1:0]           i_base,
    input  logic [15:0]                          i_amp,
    input  hwo_pkg::t_wave                       i_wave,
    input  logic                                 i_active,
    input  logic [hwo_pkg::POW_W-1:0]            i_pow,
    input  logic [hwo_pkg::WEIGHT_W-1:0]         i_weight,
    output logic signed [hwo_pkg::CONTRIB_W-1:0] o_contrib
);

    localparam int QB        = SINE_TABLE_BITS - 2;
    localparam int ROM_DEPTH = 1 << QB;
    localparam int BW        = hwo_pkg::BASE_W;
    localparam int CW        = hwo_pkg::CONTRIB_W;

    logic signed [31:0] w_sin_rom [ROM_DEPTH];
    logic signed [31:0] w_cos_rom [ROM_DEPTH];

    // quarter-wave sine and cosine in Q1.30, Taylor series to seven terms
    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        localparam longint unsigned X  =
            (longint'(g) * longint'(hwo_pkg::HALF_PI_Q30)) >> QB;
        localparam longint unsigned X2 = (X * X) >> 30;
        // sine terms
        localparam longint unsigned S1 = ((X  * X2) >> 30) / 6;
        localparam longint unsigned S2 = ((S1 * X2) >> 30) / 20;
        localparam longint unsigned S3 = ((S2 * X2) >> 30) / 42;
        localparam longint unsigned S4 = ((S3 * X2) >> 30) / 72;
        localparam longint unsigned S5 = ((S4 * X2) >> 30) / 110;
        localparam longint unsigned S6 = ((S5 * X2) >> 30) / 156;
        // cosine terms
        localparam longint unsigned C0 = 64'd1 << 30;
        localparam longint unsigned C1 = ((C0 * X2) >> 30) / 2;
        localparam longint unsigned C2 = ((C1 * X2) >> 30) / 12;
        localparam longint unsigned C3 = ((C2 * X2) >> 30) / 30;
        localparam longint unsigned C4 = ((C3 * X2) >> 30) / 56;
        localparam longint unsigned C5 = ((C4 * X2) >> 30) / 90;
        localparam longint unsigned C6 = ((C5 * X2) >> 30) / 132;
        localparam longint SIN_V = longint'(X) - longint'(S1) + longint'(S2)
                                 - longint'(S3) + longint'(S4) - longint'(S5)
                                 + longint'(S6);
        localparam longint COS_V = longint'(C0) - longint'(C1) + longint'(C2)
                                 - longint'(C3) + longint'(C4) - longint'(C5)
                                 + longint'(C6);
        assign w_sin_rom[g] = 32'(SIN_V);
        assign w_cos_rom[g] = 32'(COS_V);
    end

    // stage 1: harmonic phase and amplitude
    logic [BW-1:0] w_kbase;
    logic [48:0]   w_amp_prod;
    logic [31:0]   r_phase1;
    logic [31:0]   r_amp1;

    assign w_kbase    = i_base * BW'(HARM);
    assign w_amp_prod = i_amp * i_pow;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phase1 <= w_kbase[33:2];
            r_amp1   <= w_amp_prod[47:16];
        end
    end

    // stage 2: table read
    logic signed [31:0] r_sin2;
    logic signed [31:0] r_cos2;
    logic [1:0]         r_quad2;
    logic [31:0]        r_phase2;
    logic [31:0]        r_amp2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin2   <= w_sin_rom[r_phase1[29 -: QB]];
            r_cos2   <= w_cos_rom[r_phase1[29 -: QB]];
            r_quad2  <= r_phase1[31:30];
            r_phase2 <= r_phase1;
            r_amp2   <= r_amp1;
        end
    end

    // stage 3: multiplicand and sign per waveform
    logic signed [31:0] w_s;
    logic signed [32:0] w_sine_m;
    logic [31:0]        w_dev;
    logic signed [32:0] w_f;
    logic signed [32:0] w_f_abs;
    logic [31:0]        n_m;
    logic               n_neg;
    logic [31:0]        r_m3;
    logic               r_neg3;
    logic [31:0]        r_amp3;

    always_comb begin
        unique case (r_quad2)
            2'd0: w_s = r_sin2;
            2'd1: w_s = r_cos2;
            2'd2: w_s = -r_sin2;
            2'd3: w_s = -r_cos2;
            default: w_s = r_sin2;
        endcase
        w_sine_m = 33'sh0_4000_0000 + 33'(w_s);
        w_dev    = r_phase2[31] ? (r_phase2 - 32'h8000_0000) : (32'h8000_0000 - r_phase2);
        w_f      = 33'sh0_4000_0000 - $signed({1'b0, w_dev});
        w_f_abs  = w_f[32] ? -w_f : w_f;
        unique case (i_wave)
            hwo_pkg::WAVE_SINE: begin
                n_m   = w_sine_m[31:0];
                n_neg = 1'b0;
            end
            hwo_pkg::WAVE_SAW: begin
                n_m   = {1'b1, r_phase2[31:1]};
                n_neg = 1'b0;
            end
            hwo_pkg::WAVE_SQUARE: begin
                n_m   = hwo_pkg::SQUARE_SCALE_Q30;
                n_neg = r_phase2[31];
            end
            hwo_pkg::WAVE_TRI: begin
                n_m   = w_f_abs[31:0];
                n_neg = w_f[32];
            end
            default: begin
                n_m   = w_sine_m[31:0];
                n_neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m3   <= n_m;
            r_neg3 <= n_neg;
            r_amp3 <= r_amp2;
        end
    end

    // stage 4: amplitude product
    logic [63:0] r_p4;
    logic        r_neg4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p4   <= r_amp3 * r_m3;
            r_neg4 <= r_neg3;
        end
    end

    // stage 5: scale, offset, magnitude and sign
    logic [32:0] w_mag;
    logic        w_offs;
    logic [32:0] n_vabs;
    logic        n_vneg;
    logic [32:0] r_vabs5;
    logic        r_vneg5;

    always_comb begin
        unique case (i_wave)
            hwo_pkg::WAVE_SINE:   w_mag = r_p4[63:31];
            hwo_pkg::WAVE_SAW:    w_mag = {1'b0, r_p4[63:32]};
            hwo_pkg::WAVE_SQUARE: w_mag = r_p4[63:31];
            hwo_pkg::WAVE_TRI:    w_mag = r_p4[62:30];
            default:              w_mag = r_p4[63:31];
        endcase
        w_offs = (i_wave == hwo_pkg::WAVE_SQUARE) || (i_wave == hwo_pkg::WAVE_TRI);
        if (!w_offs) begin
            n_vabs = w_mag;
            n_vneg = 1'b0;
        end else if (!r_neg4) begin
            n_vabs = w_mag + {1'b0, hwo_pkg::HALF_Q30};
            n_vneg = 1'b0;
        end else if (w_mag > {1'b0, hwo_pkg::HALF_Q30}) begin
            n_vabs = w_mag - {1'b0, hwo_pkg::HALF_Q30};
            n_vneg = 1'b1;
        end else begin
            n_vabs = {1'b0, hwo_pkg::HALF_Q30} - w_mag;
            n_vneg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vabs5 <= n_vabs;
            r_vneg5 <= n_vneg;
        end
    end

    // stage 6: weight product
    logic [57:0] r_wp6;
    logic        r_vneg6;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wp6   <= r_vabs5 * i_weight;
            r_vneg6 <= r_vneg5;
        end
    end

    // stage 7: truncate toward zero, restore sign, mask unused harmonics
    logic signed [CW-1:0] w_term;
    logic signed [CW-1:0] r_contrib7;

    assign w_term = $signed(CW'(r_wp6[57:24]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_contrib7 <= !i_active ? '0 : (r_vneg6 ? -w_term : w_term);
        end
    end

    assign o_contrib = r_contrib7;

endmodule

>>> hdl/harmonic_waveform_oscillator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_waveform_oscillator_top
// additive harmonic oscillator: one time point in, one Q3.16 sample out
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_time_value, i_base_frequency,
//                                                 i_note_amplitude
//  output    out        o_valid / i_stall         o_sample_value
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  one request per cycle while o_stall is low; an accepted item passes through
//  the product stage, seven lane stages, the sum stage and the output register
//  a stall on the output while o_valid is high freezes every stage and raises o_stall
//  after reset and after a write of harmonic_count or decay_factor the weight
//  unit rebuilds its table: decay powers first, then each weight by a serial
//  divider, with o_stall high meanwhile
// ----------------------------------------------------------------------------
module harmonic_waveform_oscillator_top #(
    parameter int MAX_HARMONICS   = 8,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_time_value,
    input  logic [23:0]        i_base_frequency,
    input  logic [15:0]        i_note_amplitude,
    // result output
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [19:0] o_sample_value,
    // register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int CNT_W    = $clog2(MAX_HARMONICS + 1);
    localparam int LANE_LAT = 7;
    localparam int PIPE_LEN = LANE_LAT + 3;
    localparam int CW       = hwo_pkg::CONTRIB_W;
    localparam int SUM_W    = CW + $clog2(MAX_HARMONICS) + 1;

    // configuration registers
    hwo_pkg::t_wave r_wave;
    logic [3:0]     r_count;
    logic [15:0]    r_decay;
    logic           w_cfg_wr;
    logic           w_restart;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    // weights depend on count and decay only
    assign w_restart   = w_cfg_wr && ((i_cfg_index == hwo_pkg::CFG_IDX_COUNT) ||
                                      (i_cfg_index == hwo_pkg::CFG_IDX_DECAY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave  <= hwo_pkg::t_wave'(hwo_pkg::RST_WAVE);
            r_count <= hwo_pkg::RST_COUNT;
            r_decay <= hwo_pkg::RST_DECAY;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                hwo_pkg::CFG_IDX_WAVE:  r_wave  <= hwo_pkg::t_wave'(i_cfg_data[1:0]);
                hwo_pkg::CFG_IDX_COUNT: r_count <= i_cfg_data[3:0];
                hwo_pkg::CFG_IDX_DECAY: r_decay <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // counts above the lane count use every lane
    logic [CNT_W-1:0] w_n_eff;
    assign w_n_eff = (int'(r_count) > MAX_HARMONICS) ? CNT_W'(MAX_HARMONICS)
                                                     : CNT_W'(r_count);

    // weight table
    logic [hwo_pkg::POW_W-1:0]    w_pow    [MAX_HARMONICS];
    logic [hwo_pkg::WEIGHT_W-1:0] w_weight [MAX_HARMONICS];
    logic                         w_busy;

    hwo_coef #(
        .MAX_HARMONICS (MAX_HARMONICS),
        .CNT_W         (CNT_W)
    ) u_coef (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_restart),
        .i_decay  (r_decay),
        .i_count  (w_n_eff),
        .o_pow    (w_pow),
        .o_weight (w_weight),
        .o_busy   (w_busy)
    );

    // global advance: the whole pipe moves unless the output is held
    logic                w_en;
    logic [PIPE_LEN-1:0] r_vld;

    assign w_en    = !r_vld[PIPE_LEN-1] || !i_stall;
    assign o_stall = w_busy || !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LEN-2:0], i_valid && !w_busy};
        end
    end

    // stage 0: time times frequency, only the bits that reach a phase
    logic [55:0]                 w_base_prod;
    logic [hwo_pkg::BASE_W-1:0]  r_base;
    logic [15:0]                 r_amp;

    assign w_base_prod = i_time_value * i_base_frequency;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_base <= w_base_prod[hwo_pkg::BASE_W-1:0];
            r_amp  <= i_note_amplitude;
        end
    end

    // harmonic lanes
    logic signed [CW-1:0] w_contrib [MAX_HARMONICS];

    for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_lane
        hwo_lane #(
            .HARM            (g + 1),
            .SINE_TABLE_BITS (SINE_TABLE_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_base    (r_base),
            .i_amp     (r_amp),
            .i_wave    (r_wave),
            .i_active  (int'(w_n_eff) >= g + 1),
            .i_pow     (w_pow[g]),
            .i_weight  (w_weight[g]),
            .o_contrib (w_contrib[g])
        );
    end

    // sum of all harmonic terms
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] r_sum;

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < MAX_HARMONICS; i++) begin
            w_sum = w_sum + SUM_W'(w_contrib[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= w_sum;
        end
    end

    // Q.30 to Q3.16 toward zero, then saturate
    logic [SUM_W-1:0]   w_mag;
    logic [SUM_W-1:0]   w_q;
    logic signed [19:0] n_sample;
    logic signed [19:0] r_sample;

    always_comb begin
        w_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        w_q   = w_mag >> 14;
        if (!r_sum[SUM_W-1]) begin
            n_sample = (w_q > SUM_W'(hwo_pkg::OUT_MAX)) ? 20'(hwo_pkg::OUT_MAX)
                                                        : 20'(w_q);
        end else begin
            n_sample = (w_q > SUM_W'(-hwo_pkg::OUT_MIN)) ? 20'(hwo_pkg::OUT_MIN)
                                                         : 20'(-w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sample <= n_sample;
        end
    end

    assign o_valid        = r_vld[PIPE_LEN-1];
    assign o_sample_value = r_sample;

endmodule
